### hdl/hdle_pkg.sv
// Shared types and constants for the HTTP Date line to epoch converter.
// Depends on nothing; used by hdle_parser, hdle_epoch and the top level.
`default_nettype none

package hdle_pkg;

	// Width of each numeric field accumulator; values saturate at the top.
	localparam int unsigned ACC_W = 14;
	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	// Month text is held as three bytes, first byte highest.
	localparam int unsigned MON_W = 24;

	// Width of the seconds result.
	localparam int unsigned EPOCH_W = 40;

	// Default digit bound for one numeric field.
	localparam int unsigned MAX_DIGITS_DEF = 4;

	// Fields of one finished line, handed from the parser to the epoch pipe.
	typedef struct packed {
		logic             bad;
		logic [MON_W-1:0] month_chars;
		logic [ACC_W-1:0] year;
		logic [ACC_W-1:0] day;
		logic [ACC_W-1:0] hour;
		logic [ACC_W-1:0] minute;
		logic [ACC_W-1:0] second;
	} line_fields_t;

endpackage

`default_nettype wire

### hdl/hdle_parser.sv
// Byte-wise parser for "Date: Www, DD Mon YYYY HH:MM:SS" header lines.
// Depends on hdle_pkg; hands a snapshot of each finished line to hdle_epoch.
`default_nettype none

module hdle_parser #(
	parameter int unsigned MAX_DIGITS = hdle_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    byte_valid,
	output logic                         byte_stall,
	input  wire logic [7:0]              char_byte,
	input  wire logic                    line_last,
	output logic                         line_valid_s1,
	output hdle_pkg::line_fields_t       line_s1,
	input  wire logic                    line_ready_s2
);
	import hdle_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

	// Position in the header format, one-hot.
	typedef enum logic [19:0] {
		PH_PREFIX0 = 20'h00001,
		PH_PREFIX1 = 20'h00002,
		PH_PREFIX2 = 20'h00004,
		PH_PREFIX3 = 20'h00008,
		PH_PREFIX4 = 20'h00010,
		PH_WDAY_WS = 20'h00020,
		PH_WDAY    = 20'h00040,
		PH_DAY_WS  = 20'h00080,
		PH_DAY     = 20'h00100,
		PH_MON_WS  = 20'h00200,
		PH_MON     = 20'h00400,
		PH_YEAR_WS = 20'h00800,
		PH_YEAR    = 20'h01000,
		PH_HOUR_WS = 20'h02000,
		PH_HOUR    = 20'h04000,
		PH_MIN_WS  = 20'h08000,
		PH_MIN     = 20'h10000,
		PH_SEC_WS  = 20'h20000,
		PH_SEC     = 20'h40000,
		PH_DONE    = 20'h80000
	} phase_t;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_E     = 8'h65;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	phase_t           phase_q, n_phase;
	logic [1:0]       wlen_q, n_wlen;
	logic [MON_W-1:0] month_q, n_month;
	logic [ACC_W-1:0] day_q, n_day;
	logic [ACC_W-1:0] year_q, n_year;
	logic [ACC_W-1:0] hour_q, n_hour;
	logic [ACC_W-1:0] min_q, n_min;
	logic [ACC_W-1:0] sec_q, n_sec;
	logic [CNT_W-1:0] dcnt_q, n_dcnt;
	logic             bad_q, n_bad;

	logic             ws, dg, dig_full, nul_bad, accept, ready_s1;
	logic [ACC_W-1:0] cur_acc, step_acc, first_acc;
	logic [ACC_W+3:0] mac;

	assign ws       = is_space(char_byte);
	assign dg       = is_digit(char_byte);
	assign dig_full = (dcnt_q >= CNT_W'(MAX_DIGITS));

	// The snapshot register frees up when empty or when the epoch pipe takes it.
	assign ready_s1   = !line_valid_s1 || line_ready_s2;
	assign byte_stall = !ready_s1;
	assign accept     = byte_valid && !byte_stall;

	// One shared multiply-accumulate for whichever number is being read.
	always_comb begin
		unique case (phase_q)
			PH_YEAR: cur_acc = year_q;
			PH_HOUR: cur_acc = hour_q;
			PH_MIN:  cur_acc = min_q;
			PH_SEC:  cur_acc = sec_q;
			default: cur_acc = day_q;
		endcase
	end

	assign mac       = {1'b0, cur_acc, 3'b000} + {3'b000, cur_acc, 1'b0}
	                 + {{(ACC_W){1'b0}}, char_byte[3:0]};
	assign step_acc  = (mac > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : mac[ACC_W-1:0];
	assign first_acc = {{(ACC_W-4){1'b0}}, char_byte[3:0]};

	// A NUL byte breaks the line anywhere past the prefix until the seconds.
	assign nul_bad = (char_byte == CH_NUL) && (phase_q != PH_PREFIX0)
	              && (phase_q != PH_PREFIX1) && (phase_q != PH_PREFIX2)
	              && (phase_q != PH_PREFIX3) && (phase_q != PH_PREFIX4)
	              && (phase_q != PH_SEC) && (phase_q != PH_DONE);

	// Next parse state for the byte on the input.
	always_comb begin
		n_phase = phase_q;
		n_wlen  = wlen_q;
		n_month = month_q;
		n_day   = day_q;
		n_year  = year_q;
		n_hour  = hour_q;
		n_min   = min_q;
		n_sec   = sec_q;
		n_dcnt  = dcnt_q;
		n_bad   = bad_q;
		if (!bad_q) begin
			if (nul_bad) begin
				n_bad = 1'b1;
			end else begin
				unique case (phase_q)
					PH_PREFIX0: begin
						if (char_byte == CH_D) n_phase = PH_PREFIX1;
						else n_bad = 1'b1;
					end
					PH_PREFIX1: begin
						if (char_byte == CH_A) n_phase = PH_PREFIX2;
						else n_bad = 1'b1;
					end
					PH_PREFIX2: begin
						if (char_byte == CH_T) n_phase = PH_PREFIX3;
						else n_bad = 1'b1;
					end
					PH_PREFIX3: begin
						if (char_byte == CH_E) n_phase = PH_PREFIX4;
						else n_bad = 1'b1;
					end
					PH_PREFIX4: begin
						if (char_byte == CH_COLON) n_phase = PH_WDAY_WS;
						else n_bad = 1'b1;
					end
					PH_WDAY_WS: begin
						if (char_byte == CH_COMMA) begin
							n_bad = 1'b1;
						end else if (!ws) begin
							n_wlen  = 2'd1;
							n_phase = PH_WDAY;
						end
					end
					PH_WDAY: begin
						if (char_byte == CH_COMMA) n_phase = PH_DAY_WS;
						else if (wlen_q == 2'd3) n_bad = 1'b1;
						else n_wlen = wlen_q + 2'd1;
					end
					PH_DAY_WS: begin
						if (dg) begin
							n_day   = first_acc;
							n_dcnt  = CNT_W'(1);
							n_phase = PH_DAY;
						end else if (!ws) begin
							n_bad = 1'b1;
						end
					end
					PH_DAY: begin
						if (dg) begin
							if (dig_full) begin
								n_bad = 1'b1;
							end else begin
								n_day  = step_acc;
								n_dcnt = dcnt_q + CNT_W'(1);
							end
						end else if (ws) begin
							n_phase = PH_MON_WS;
						end else begin
							// Any other byte right after the day starts the month.
							n_month = {16'h0000, char_byte};
							n_dcnt  = CNT_W'(1);
							n_phase = PH_MON;
						end
					end
					PH_MON_WS: begin
						if (!ws) begin
							n_month = {16'h0000, char_byte};
							n_dcnt  = CNT_W'(1);
							n_phase = PH_MON;
						end
					end
					PH_MON: begin
						if (ws) begin
							n_bad = 1'b1;
						end else begin
							n_month = {month_q[MON_W-9:0], char_byte};
							if (dcnt_q + CNT_W'(1) >= CNT_W'(3)) begin
								n_dcnt  = '0;
								n_phase = PH_YEAR_WS;
							end else begin
								n_dcnt = dcnt_q + CNT_W'(1);
							end
						end
					end
					PH_YEAR_WS: begin
						if (dg) begin
							n_year  = first_acc;
							n_dcnt  = CNT_W'(1);
							n_phase = PH_YEAR;
						end else if (!ws) begin
							n_bad = 1'b1;
						end
					end
					PH_YEAR: begin
						if (dg) begin
							if (dig_full) begin
								n_bad = 1'b1;
							end else begin
								n_year = step_acc;
								n_dcnt = dcnt_q + CNT_W'(1);
							end
						end else if (ws) begin
							n_phase = PH_HOUR_WS;
						end else begin
							n_bad = 1'b1;
						end
					end
					PH_HOUR_WS: begin
						if (dg) begin
							n_hour  = first_acc;
							n_dcnt  = CNT_W'(1);
							n_phase = PH_HOUR;
						end else if (!ws) begin
							n_bad = 1'b1;
						end
					end
					PH_HOUR: begin
						if (dg) begin
							if (dig_full) begin
								n_bad = 1'b1;
							end else begin
								n_hour = step_acc;
								n_dcnt = dcnt_q + CNT_W'(1);
							end
						end else if (char_byte == CH_COLON) begin
							n_phase = PH_MIN_WS;
						end else begin
							n_bad = 1'b1;
						end
					end
					PH_MIN_WS: begin
						if (dg) begin
							n_min   = first_acc;
							n_dcnt  = CNT_W'(1);
							n_phase = PH_MIN;
						end else if (!ws) begin
							n_bad = 1'b1;
						end
					end
					PH_MIN: begin
						if (dg) begin
							if (dig_full) begin
								n_bad = 1'b1;
							end else begin
								n_min  = step_acc;
								n_dcnt = dcnt_q + CNT_W'(1);
							end
						end else if (char_byte == CH_COLON) begin
							n_phase = PH_SEC_WS;
						end else begin
							n_bad = 1'b1;
						end
					end
					PH_SEC_WS: begin
						if (dg) begin
							n_sec   = first_acc;
							n_dcnt  = CNT_W'(1);
							n_phase = PH_SEC;
						end else if (!ws) begin
							n_bad = 1'b1;
						end
					end
					PH_SEC: begin
						if (dg) begin
							if (dig_full) begin
								n_bad = 1'b1;
							end else begin
								n_sec  = step_acc;
								n_dcnt = dcnt_q + CNT_W'(1);
							end
						end else begin
							n_phase = PH_DONE;
						end
					end
					PH_DONE: begin
						n_phase = PH_DONE;
					end
					default: begin
						n_bad = 1'b1;
					end
				endcase
			end
		end
	end

	// Parse state; it returns to its start after the last word of a line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX0;
			wlen_q  <= '0;
			month_q <= '0;
			day_q   <= '0;
			year_q  <= '0;
			hour_q  <= '0;
			min_q   <= '0;
			sec_q   <= '0;
			dcnt_q  <= '0;
			bad_q   <= 1'b0;
		end else if (accept) begin
			if (line_last) begin
				phase_q <= PH_PREFIX0;
				wlen_q  <= '0;
				month_q <= '0;
				day_q   <= '0;
				year_q  <= '0;
				hour_q  <= '0;
				min_q   <= '0;
				sec_q   <= '0;
				dcnt_q  <= '0;
				bad_q   <= 1'b0;
			end else begin
				phase_q <= n_phase;
				wlen_q  <= n_wlen;
				month_q <= n_month;
				day_q   <= n_day;
				year_q  <= n_year;
				hour_q  <= n_hour;
				min_q   <= n_min;
				sec_q   <= n_sec;
				dcnt_q  <= n_dcnt;
				bad_q   <= n_bad;
			end
		end
	end

	// Snapshot valid flag for a finished line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			line_valid_s1 <= accept && line_last;
		end
	end

	// Snapshot of the fields as they stand after the last word.
	always_ff @(posedge clk) begin
		if (accept && line_last) begin
			line_s1.bad         <= n_bad || !((n_phase == PH_SEC) || (n_phase == PH_DONE));
			line_s1.month_chars <= n_month;
			line_s1.year        <= n_year;
			line_s1.day         <= n_day;
			line_s1.hour        <= n_hour;
			line_s1.minute      <= n_min;
			line_s1.second      <= n_sec;
		end
	end

endmodule

`default_nettype wire

### hdl/hdle_epoch.sv
// Three-stage pipe that turns parsed date fields into epoch seconds.
// Depends on hdle_pkg; fed by hdle_parser, drives the result channel.
`default_nettype none

module hdle_epoch (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          line_valid_s1,
	input  wire hdle_pkg::line_fields_t        line_s1,
	output logic                               line_ready_s2,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic                               date_valid,
	output logic [hdle_pkg::EPOCH_W-1:0]       epoch_seconds
);
	import hdle_pkg::*;

	localparam int unsigned Q_W    = 8;
	localparam int unsigned PROD_W = ACC_W + 13;
	localparam int unsigned DAYS_W = 26;
	localparam int unsigned TOD_W  = 27;
	localparam int unsigned TOT_W  = 44;

	// floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit y.
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int unsigned RECIP_SH  = 19;

	localparam logic [ACC_W-1:0] YEAR_MIN    = ACC_W'(1970);
	localparam logic [ACC_W-1:0] YEAR_MAX    = ACC_W'(9999);
	// Days from year 0 offsets: 365 * 1970, leap days through 1969, and day one.
	localparam int unsigned      DAYS_OFFSET = 365 * 1970 + 477 + 1;
	localparam int unsigned      SEC_PER_DAY = 86400;

	localparam logic [MON_W-1:0] MON_JAN = 24'h4A616E;
	localparam logic [MON_W-1:0] MON_FEB = 24'h466562;
	localparam logic [MON_W-1:0] MON_MAR = 24'h4D6172;
	localparam logic [MON_W-1:0] MON_APR = 24'h417072;
	localparam logic [MON_W-1:0] MON_MAY = 24'h4D6179;
	localparam logic [MON_W-1:0] MON_JUN = 24'h4A756E;
	localparam logic [MON_W-1:0] MON_JUL = 24'h4A756C;
	localparam logic [MON_W-1:0] MON_AUG = 24'h417567;
	localparam logic [MON_W-1:0] MON_SEP = 24'h536570;
	localparam logic [MON_W-1:0] MON_OCT = 24'h4F6374;
	localparam logic [MON_W-1:0] MON_NOV = 24'h4E6F76;
	localparam logic [MON_W-1:0] MON_DEC = 24'h446563;

	typedef struct packed {
		logic       found;
		logic [3:0] idx;
	} month_hit_t;

	// Month abbreviation to index 0..11.
	function automatic month_hit_t month_lookup(input logic [MON_W-1:0] m);
		month_hit_t h;
		h.found = 1'b1;
		unique case (m)
			MON_JAN: h.idx = 4'd0;
			MON_FEB: h.idx = 4'd1;
			MON_MAR: h.idx = 4'd2;
			MON_APR: h.idx = 4'd3;
			MON_MAY: h.idx = 4'd4;
			MON_JUN: h.idx = 4'd5;
			MON_JUL: h.idx = 4'd6;
			MON_AUG: h.idx = 4'd7;
			MON_SEP: h.idx = 4'd8;
			MON_OCT: h.idx = 4'd9;
			MON_NOV: h.idx = 4'd10;
			MON_DEC: h.idx = 4'd11;
			default: begin
				h.found = 1'b0;
				h.idx   = 4'd0;
			end
		endcase
		return h;
	endfunction

	// Days in the year before the first of each month, common year.
	function automatic logic [8:0] days_before(input logic [3:0] idx);
		logic [8:0] d;
		unique case (idx)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	logic ready_s3, ready_out;

	// Stage 2 registers: month index, range check, centuries of the year.
	logic             valid_s2, bad_s2;
	logic [3:0]       idx_s2;
	logic [ACC_W-1:0] year_s2, y1_s2, day_s2, hour_s2, min_s2, sec_s2;
	logic [Q_W-1:0]   q1_s2, qy_s2;

	// Stage 3 registers: whole days and time of day.
	logic                     valid_s3, bad_s3;
	logic signed [DAYS_W-1:0] days_s3;
	logic [TOD_W-1:0]         tod_s3;

	// Backpressure: each stage moves on when it is empty or its successor moves.
	assign ready_out     = !result_valid || !result_stall;
	assign ready_s3      = !valid_s3 || ready_out;
	assign line_ready_s2 = !valid_s2 || ready_s3;

	// Stage 2 logic.
	month_hit_t        hit;
	logic [ACC_W-1:0]  y1;
	logic [PROD_W-1:0] prod_y1, prod_y;
	logic              year_ok;

	assign hit     = month_lookup(line_s1.month_chars);
	assign y1      = line_s1.year - ACC_W'(1);
	assign prod_y1 = PROD_W'(y1) * PROD_W'(RECIP_100);
	assign prod_y  = PROD_W'(line_s1.year) * PROD_W'(RECIP_100);
	assign year_ok = (line_s1.year >= YEAR_MIN) && (line_s1.year <= YEAR_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (line_ready_s2) begin
			valid_s2 <= line_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (line_ready_s2 && line_valid_s1) begin
			bad_s2  <= line_s1.bad || !hit.found || !year_ok;
			idx_s2  <= hit.idx;
			year_s2 <= line_s1.year;
			y1_s2   <= y1;
			q1_s2   <= prod_y1[RECIP_SH +: Q_W];
			qy_s2   <= prod_y[RECIP_SH +: Q_W];
			day_s2  <= line_s1.day;
			hour_s2 <= line_s1.hour;
			min_s2  <= line_s1.minute;
			sec_s2  <= line_s1.second;
		end
	end

	// Stage 3 logic: days since the epoch and seconds within the day.
	logic [DAYS_W-1:0] days_pos, days_neg;
	logic [Q_W+6:0]    qy_x100;
	logic              is_leap, leap_add;
	logic [TOD_W-1:0]  tod;

	assign qy_x100  = {1'b0, qy_s2, 6'b0} + {2'b0, qy_s2, 5'b0} + {5'b0, qy_s2, 2'b0};
	assign is_leap  = (year_s2[1:0] == 2'b00)
	               && ((qy_x100 != (Q_W+7)'(year_s2)) || (qy_s2[1:0] == 2'b00));
	assign leap_add = is_leap && (idx_s2 >= 4'd2);

	assign days_pos = DAYS_W'(year_s2) * DAYS_W'(365)
	                + DAYS_W'(y1_s2[ACC_W-1:2])
	                + DAYS_W'(q1_s2[Q_W-1:2])
	                + DAYS_W'(days_before(idx_s2))
	                + DAYS_W'(leap_add)
	                + DAYS_W'(day_s2);
	assign days_neg = DAYS_W'(q1_s2) + DAYS_W'(DAYS_OFFSET);

	assign tod = TOD_W'(hour_s2) * TOD_W'(3600)
	           + TOD_W'(min_s2) * TOD_W'(60)
	           + TOD_W'(sec_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			bad_s3  <= bad_s2;
			days_s3 <= $signed(days_pos) - $signed(days_neg);
			tod_s3  <= tod;
		end
	end

	// Output stage: scale days to seconds and add the time of day.
	logic signed [TOT_W-1:0] total;
	logic                    ok;

	assign total = TOT_W'(days_s3) * $signed(TOT_W'(SEC_PER_DAY))
	             + $signed(TOT_W'(tod_s3));
	assign ok    = !bad_s3 && !total[TOT_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (ready_out) begin
			result_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_s3) begin
			date_valid    <= ok;
			epoch_seconds <= ok ? total[EPOCH_W-1:0] : '0;
		end
	end

endmodule

`default_nettype wire

### hdl/http_date_line_to_epoch.sv
// HTTP Date header line to Unix epoch seconds.
//
// Input channel: one header-line word (char_byte, line_last) per accepted
// cycle on byte_valid / byte_stall. Output channel: one result word
// (date_valid, epoch_seconds) per line on result_valid / result_stall, given
// for the word that carries line_last. epoch_seconds is zero when
// date_valid is low.
// Throughput: one input word per cycle while byte_stall is low. The parser
// updates its state in the cycle a word is taken; the epoch sum runs in a
// three-register pipe. A finished line moves from the snapshot register
// through the stage 2, stage 3 and output registers in that order.
// When the receiver stalls, the result holds in the output register and the
// pipe behind it keeps filling; byte_stall rises only once the snapshot
// register and every pipe stage hold a finished line.
// Reset clears the parse state and every valid flag; the next word is taken
// as the first word of a new line.
// Depends on hdle_pkg, hdle_parser and hdle_epoch.
`default_nettype none

module http_date_line_to_epoch #(
	parameter int unsigned MAX_DIGITS = hdle_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        byte_valid,
	output logic                             byte_stall,
	input  wire logic [7:0]                  char_byte,
	input  wire logic                        line_last,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output logic                             date_valid,
	output logic [hdle_pkg::EPOCH_W-1:0]     epoch_seconds
);
	import hdle_pkg::*;

	logic         line_valid_s1;
	line_fields_t line_s1;
	logic         line_ready_s2;

	// Byte-wise format parser with the finished-line snapshot register.
	hdle_parser #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.char_byte     (char_byte),
		.line_last     (line_last),
		.line_valid_s1 (line_valid_s1),
		.line_s1       (line_s1),
		.line_ready_s2 (line_ready_s2)
	);

	// Calendar arithmetic and result register.
	hdle_epoch u_epoch (
		.clk           (clk),
		.arst_n        (arst_n),
		.line_valid_s1 (line_valid_s1),
		.line_s1       (line_s1),
		.line_ready_s2 (line_ready_s2),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.date_valid    (date_valid),
		.epoch_seconds (epoch_seconds)
	);

endmodule

`default_nettype wire
